>>> src/framed_command_receiver_watchdog_defines.svh
// ----------------------------------------------------------------------------
// Framed command receiver watchdog - assertion macros
// Shared assertion macros; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_WATCHDOG_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_WATCHDOG_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/fcrw_pkg.sv
// ----------------------------------------------------------------------------
// Framed command receiver watchdog - package
// Shared types, codes and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package fcrw_pkg;

    localparam int MAX_PAYLOAD = 28;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 2);
    localparam int PADDR_W     = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] HDR1    = 8'hAA;
    localparam logic [7:0] HDR2    = 8'h55;
    localparam logic [7:0] ACK_LEN = 8'h02;
    localparam logic [7:0] MIN_LEN = 8'd2;

    localparam logic [7:0] CMD_HEARTBEAT = 8'h01;
    localparam logic [7:0] CMD_KILL      = 8'h10;
    localparam logic [7:0] CMD_START     = 8'h11;
    localparam logic [7:0] CMD_CLEAR     = 8'h12;

    localparam logic [7:0] ST_OK      = 8'd0;
    localparam logic [7:0] ST_UNKNOWN = 8'd1;
    localparam logic [7:0] ST_REFUSED = 8'd2;

    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_TICK = 1'b1;

    localparam logic [1:0] REG_WARN = 2'd0;
    localparam logic [1:0] REG_KILL = 2'd1;
    localparam logic [1:0] REG_PTMO = 2'd2;

    localparam logic [15:0] WARN_RST = 16'd2000;
    localparam logic [15:0] KILL_RST = 16'd4000;
    localparam logic [7:0]  PTMO_RST = 8'd150;

    // ack frame: AA 55 02 seq status crcL crcH
    localparam logic [2:0] IDX_HDR1   = 3'd0;
    localparam logic [2:0] IDX_HDR2   = 3'd1;
    localparam logic [2:0] IDX_LEN    = 3'd2;
    localparam logic [2:0] IDX_SEQ    = 3'd3;
    localparam logic [2:0] IDX_STATUS = 3'd4;
    localparam logic [2:0] IDX_CRCL   = 3'd5;
    localparam logic [2:0] IDX_CRCH   = 3'd6;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_KILL  = 3'd1,
        EV_START = 3'd2,
        EV_CLEAR = 3'd3,
        EV_STOP  = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        PH_HDR1 = 2'd0,
        PH_HDR2 = 2'd1,
        PH_LEN  = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef enum logic {
        DK_ACK   = 1'b0,
        DK_EVENT = 1'b1
    } t_desc_kind;

    typedef struct packed {
        logic [15:0] warn_timeout;
        logic [15:0] kill_timeout;
        logic [7:0]  parser_timeout;
    } t_cfg;

    // one pending response: a 7-byte ack or a lone watchdog event
    typedef struct packed {
        t_desc_kind  kind;
        logic [7:0]  seq;
        logic [7:0]  status;
        t_event      ev;
        logic [15:0] crc;
    } t_desc;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/framed_command_receiver_watchdog.sv
// ----------------------------------------------------------------------------
// Framed command receiver watchdog - top level
// Byte-framed command receiver (CRC-16/MODBUS checked) with ack generation
// and a millisecond link watchdog giving soft stop and hard kill events.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   ------------------------  ---------------------------------------
//  request   i_in_valid / o_in_ready   i_cmd i_rx_byte i_fault_latched
//                                      i_kill_latched
//  result    o_out_valid / i_out_ready o_tx_byte o_tx_valid o_event_res o_last
//  config    psel penable pwrite       paddr pwdata prdata pready
//
//  Each request is parsed in the cycle it is accepted; its response (none,
//  one event result, or a seven-byte ack) is registered and offered once the
//  serializer is free. The serializer plays one response and queues one more,
//  so a request is taken every cycle unless that spare slot is full.
//  Reset is synchronous and active low; there is no clearing pass.
//  Stalls or events raised during an ack fill both slots, holding off requests.
//
`include "framed_command_receiver_watchdog_defines.svh"

module framed_command_receiver_watchdog (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_fault_latched,
    input  logic                         i_kill_latched,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_tx_byte,
    output logic                         o_tx_valid,
    output logic [2:0]                   o_event_res,
    output logic                         o_last,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcrw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fcrw_pkg::*;

    t_cfg  cfg;
    t_desc desc;
    logic  desc_load;
    logic  tx_free;
    logic  in_accept;

    // a request is taken whenever the serializer can queue whatever response
    // that request may produce
    assign o_in_ready = tx_free;
    assign in_accept  = i_in_valid & tx_free;

    fcrw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // parser state and watchdog counters advance on every accepted request
    fcrw_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_cmd           (i_cmd),
        .i_rx_byte       (i_rx_byte),
        .i_fault_latched (i_fault_latched),
        .i_kill_latched  (i_kill_latched),
        .i_cfg           (cfg),
        .o_load          (desc_load),
        .o_desc          (desc)
    );

    // response registers and byte sequencer
    fcrw_tx u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (desc_load),
        .i_desc      (desc),
        .o_free      (tx_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tx_byte   (o_tx_byte),
        .o_tx_valid  (o_tx_valid),
        .o_event_res (o_event_res),
        .o_last      (o_last)
    );

    // nothing queued means the input is open
    `ASSERT_IMPLY(a_open_when_idle, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    // watchdog events travel alone
    `ASSERT_IMPLY(a_event_alone, i_clk, i_rst_n,
                  o_out_valid && !o_tx_valid,
                  o_last && o_tx_byte == 8'h00)
    // ack events ride on the first header byte
    `ASSERT_IMPLY(a_event_on_hdr, i_clk, i_rst_n,
                  o_out_valid && o_tx_valid && o_event_res != EV_NONE,
                  o_tx_byte == HDR1)
    // an ack keeps going until its last byte
    `ASSERT_NEXT(a_ack_continues, i_clk, i_rst_n,
                 o_out_valid && i_out_ready && !o_last,
                 o_out_valid && o_tx_valid)

endmodule

>>> src/fcrw_regs.sv
// ----------------------------------------------------------------------------
// Framed command receiver watchdog - configuration registers
// APB-style register file for the three timeouts.
// ----------------------------------------------------------------------------
module fcrw_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcrw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output fcrw_pkg::t_cfg              o_cfg
);
    import fcrw_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_WARN: n_cfg.warn_timeout   = pwdata[15:0];
                REG_KILL: n_cfg.kill_timeout   = pwdata[15:0];
                REG_PTMO: n_cfg.parser_timeout = pwdata[7:0];
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_timeout   <= WARN_RST;
            r_cfg.kill_timeout   <= KILL_RST;
            r_cfg.parser_timeout <= PTMO_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WARN: prdata = {16'h0000, r_cfg.warn_timeout};
            REG_KILL: prdata = {16'h0000, r_cfg.kill_timeout};
            REG_PTMO: prdata = {24'h000000, r_cfg.parser_timeout};
            default:  prdata = 32'h0000_0000;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/fcrw_parser.sv
// ----------------------------------------------------------------------------
// Framed command receiver watchdog - frame parser and link watchdog
// Consumes one byte or tick per request; emits a response descriptor.
// ----------------------------------------------------------------------------
module fcrw_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_cmd,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_fault_latched,
    input  logic           i_kill_latched,
    input  fcrw_pkg::t_cfg i_cfg,
    output logic           o_load,
    output fcrw_pkg::t_desc o_desc
);
    import fcrw_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_seq_crc, n_seq_crc;   // CRC state after the seq byte
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_fcmd, n_fcmd;
    logic [7:0]       r_crc_lo, n_crc_lo;
    logic [7:0]       r_last_seq, n_last_seq;
    logic             r_link_up, n_link_up;
    logic [7:0]       r_msb, n_msb;
    logic [15:0]      r_msc, n_msc;

    logic [7:0]  msb_inc;
    logic [15:0] msc_inc;
    logic [15:0] crc_step;
    logic        len_ok;
    logic        crc_good;
    logic [7:0]  ack_status;
    t_event      ack_ev;
    t_event      tick_ev;

    assign msb_inc  = (r_msb == 8'hFF) ? r_msb : r_msb + 8'd1;
    assign msc_inc  = (r_msc == 16'hFFFF) ? r_msc : r_msc + 16'd1;
    assign crc_step = crc16_byte(r_crc, i_rx_byte);
    assign len_ok   = (i_rx_byte >= MIN_LEN) && (i_rx_byte <= 8'(MAX_PAYLOAD));
    assign crc_good = ({i_rx_byte, r_crc_lo} == r_crc);

    // ack contents for a completed frame
    always_comb begin
        ack_status = ST_OK;
        ack_ev     = EV_NONE;
        if (r_seq != r_last_seq) begin
            unique case (r_fcmd)
                CMD_KILL:      ack_ev = EV_KILL;
                CMD_START: begin
                    if (i_fault_latched) begin
                        ack_status = ST_REFUSED;
                    end else begin
                        ack_ev = EV_START;
                    end
                end
                CMD_CLEAR:     ack_ev = EV_CLEAR;
                CMD_HEARTBEAT: ack_ev = EV_NONE;
                default:       ack_status = ST_UNKNOWN;
            endcase
        end
    end

    always_comb begin
        tick_ev = EV_NONE;
        if (!i_kill_latched && r_link_up) begin
            if (msc_inc > i_cfg.kill_timeout) begin
                tick_ev = EV_KILL;
            end else if (msc_inc > i_cfg.warn_timeout) begin
                tick_ev = EV_STOP;
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_crc      = r_crc;
        n_seq_crc  = r_seq_crc;
        n_seq      = r_seq;
        n_fcmd     = r_fcmd;
        n_crc_lo   = r_crc_lo;
        n_last_seq = r_last_seq;
        n_link_up  = r_link_up;
        n_msb      = r_msb;
        n_msc      = r_msc;
        o_load     = 1'b0;
        o_desc     = '0;
        if (i_accept) begin
            if (i_cmd == ITEM_TICK) begin
                n_msb = msb_inc;
                n_msc = msc_inc;
                // stale partial frame
                if (r_phase != PH_HDR1 && msb_inc > i_cfg.parser_timeout) begin
                    n_phase = PH_HDR1;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_crc   = CRC_INIT;
                end
                if (tick_ev != EV_NONE) begin
                    o_load      = 1'b1;
                    o_desc.kind = DK_EVENT;
                    o_desc.ev   = tick_ev;
                end
            end else begin
                n_msb = 8'h00;
                unique case (r_phase)
                    PH_HDR1: begin
                        if (i_rx_byte == HDR1) begin
                            n_phase = PH_HDR2;
                        end
                    end
                    PH_HDR2: begin
                        if (i_rx_byte == HDR2) begin
                            n_phase = PH_LEN;
                        end else begin
                            n_phase = PH_HDR1;
                            n_len   = '0;
                            n_cnt   = '0;
                            n_crc   = CRC_INIT;
                        end
                    end
                    PH_LEN: begin
                        n_cnt = '0;
                        n_crc = CRC_INIT;
                        if (len_ok) begin
                            n_len   = i_rx_byte[CNT_W-1:0];
                            n_phase = PH_BODY;
                        end else begin
                            n_len   = '0;
                            n_phase = PH_HDR1;
                        end
                    end
                    PH_BODY: begin
                        if (r_cnt < r_len) begin
                            if (r_cnt == '0) begin
                                n_seq     = i_rx_byte;
                                n_seq_crc = crc_step;
                            end else if (r_cnt == CNT_W'(1)) begin
                                n_fcmd = i_rx_byte;
                            end
                            n_crc = crc_step;
                            n_cnt = CNT_W'(r_cnt + 1'b1);
                        end else if (r_cnt == r_len) begin
                            n_crc_lo = i_rx_byte;
                            n_cnt    = CNT_W'(r_cnt + 1'b1);
                        end else begin
                            n_phase = PH_HDR1;
                            n_len   = '0;
                            n_cnt   = '0;
                            n_crc   = CRC_INIT;
                            if (crc_good) begin
                                n_msc       = 16'h0000;
                                n_link_up   = 1'b1;
                                n_last_seq  = r_seq;
                                o_load      = 1'b1;
                                o_desc.kind = DK_ACK;
                                o_desc.seq  = r_seq;
                                o_desc.status = ack_status;
                                o_desc.ev   = ack_ev;
                                o_desc.crc  = crc16_byte(r_seq_crc, ack_status);
                            end
                        end
                    end
                    default: n_phase = PH_HDR1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR1;
            r_len      <= '0;
            r_cnt      <= '0;
            r_crc      <= CRC_INIT;
            r_seq_crc  <= CRC_INIT;
            r_seq      <= 8'h00;
            r_fcmd     <= 8'h00;
            r_crc_lo   <= 8'h00;
            r_last_seq <= 8'hFF;
            r_link_up  <= 1'b0;
            r_msb      <= 8'h00;
            r_msc      <= 16'h0000;
        end else begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_cnt      <= n_cnt;
            r_crc      <= n_crc;
            r_seq_crc  <= n_seq_crc;
            r_seq      <= n_seq;
            r_fcmd     <= n_fcmd;
            r_crc_lo   <= n_crc_lo;
            r_last_seq <= n_last_seq;
            r_link_up  <= n_link_up;
            r_msb      <= n_msb;
            r_msc      <= n_msc;
        end
    end

endmodule

>>> src/fcrw_tx.sv
// ----------------------------------------------------------------------------
// Framed command receiver watchdog - response serializer
// Plays the active response descriptor out one result per handshake and
// keeps one more descriptor queued behind it.
// ----------------------------------------------------------------------------
module fcrw_tx (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  fcrw_pkg::t_desc i_desc,
    output logic            o_free,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_tx_byte,
    output logic            o_tx_valid,
    output logic [2:0]      o_event_res,
    output logic            o_last
);
    import fcrw_pkg::*;

    logic       r_busy, n_busy;
    logic [2:0] r_idx, n_idx;
    t_desc      r_desc, n_desc;
    logic       r_pend_vld, n_pend_vld;   // response waiting behind the active one
    t_desc      r_pend, n_pend;
    logic       is_ack;
    logic       take;
    logic       done;

    assign is_ack = (r_desc.kind == DK_ACK);
    assign o_last = is_ack ? (r_idx == IDX_CRCH) : 1'b1;
    assign take   = r_busy & i_out_ready;
    assign done   = take & o_last;
    assign o_free = ~r_pend_vld | done;

    always_comb begin
        n_busy     = r_busy;
        n_idx      = r_idx;
        n_desc     = r_desc;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        if (take) begin
            if (o_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        // queued response moves up once the active one is gone
        if (!n_busy && r_pend_vld) begin
            n_busy     = 1'b1;
            n_idx      = IDX_HDR1;
            n_desc     = r_pend;
            n_pend_vld = 1'b0;
        end
        if (i_load) begin
            if (!n_busy) begin
                n_busy = 1'b1;
                n_idx  = IDX_HDR1;
                n_desc = i_desc;
            end else begin
                n_pend_vld = 1'b1;
                n_pend     = i_desc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_idx      <= IDX_HDR1;
            r_pend_vld <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_pend <= n_pend;
    end

    always_comb begin
        unique case (r_idx)
            IDX_HDR1:   o_tx_byte = HDR1;
            IDX_HDR2:   o_tx_byte = HDR2;
            IDX_LEN:    o_tx_byte = ACK_LEN;
            IDX_SEQ:    o_tx_byte = r_desc.seq;
            IDX_STATUS: o_tx_byte = r_desc.status;
            IDX_CRCL:   o_tx_byte = r_desc.crc[7:0];
            IDX_CRCH:   o_tx_byte = r_desc.crc[15:8];
            default:    o_tx_byte = 8'h00;
        endcase
        if (!is_ack) begin
            o_tx_byte = 8'h00;
        end
    end

    assign o_out_valid = r_busy;
    assign o_tx_valid  = is_ack;
    assign o_event_res = (r_idx == IDX_HDR1) ? r_desc.ev : EV_NONE;

endmodule
